### sv/cpob_pkg.sv
// Shared constants and types for the closest-point-on-oriented-box block.
`timescale 1ns / 1ps

package cpob_pkg;

    // Default datapath sizing
    localparam int COORD_BITS_DEF     = 32;
    localparam int AXIS_FRAC_BITS_DEF = 14;

    // Axis entries are fixed 16-bit signed fields, three to a register
    localparam int ENTRY_BITS = 16;
    localparam int NUM_AXES   = 3;
    localparam int AXIS_BITS  = NUM_AXES * ENTRY_BITS;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = AXIS_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_AXIS_COLUMN_X = 3'd0,
        REG_AXIS_COLUMN_Y = 3'd1,
        REG_AXIS_COLUMN_Z = 3'd2,
        REG_HALF_EXTENT_X = 3'd3,
        REG_HALF_EXTENT_Y = 3'd4,
        REG_HALF_EXTENT_Z = 3'd5
    } cfg_reg_t;

    // Reset values: identity rotation, unit half-extents
    localparam logic [AXIS_BITS-1:0] AXIS_X_RESET = 48'd16384;
    localparam logic [AXIS_BITS-1:0] AXIS_Y_RESET = 48'd1073741824;
    localparam logic [AXIS_BITS-1:0] AXIS_Z_RESET = 48'd70368744177664;
    localparam int                   HALF_RESET   = 65536;

    // Register stages from query to result, output register included
    localparam int PIPE_STAGES = 5;

endpackage

### sv/cpob_if.sv
// Valid/ready channel interfaces for query points and closest-point results.
`timescale 1ns / 1ps

interface cpob_query_if #(
    parameter int COORD_BITS = cpob_pkg::COORD_BITS_DEF
);
    import cpob_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface cpob_closest_if #(
    parameter int COORD_BITS = cpob_pkg::COORD_BITS_DEF
);
    import cpob_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] closest_x;
    logic signed [COORD_BITS-1:0] closest_y;
    logic signed [COORD_BITS-1:0] closest_z;

    modport source (output valid, output closest_x, output closest_y, output closest_z,
                    input ready);
    modport sink   (input valid, input closest_x, input closest_y, input closest_z,
                    output ready);
endinterface

### sv/closest_point_on_oriented_box.sv
// Pipelined closest point on a solid oriented box, fixed point.
`timescale 1ns / 1ps

// Channel   Dir  Payload                          Handshake
// --------  ---  -------------------------------  ----------------------
// query     in   point_x/y/z, signed Q15.16       valid & ready
// result    out  closest_x/y/z, signed Q15.16     valid & ready
// cfg       in   cfg_index, cfg_data (48 bits)    cfg_we, no back-pressure
//
// Five register stages: projection products, rounded distance, clamp,
// back-projection products, sum/round/saturate into the output register.
// One transaction per cycle is sustained while the result sink is ready.
// Each stage holds only when it is full and the stage after it is held, so
// bubbles close up under back-pressure. Reset empties the pipeline and loads
// the identity axes and unit half-extents.

module closest_point_on_oriented_box #(
    parameter int COORD_BITS     = cpob_pkg::COORD_BITS_DEF,
    parameter int AXIS_FRAC_BITS = cpob_pkg::AXIS_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cpob_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cpob_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    cpob_query_if.sink                          query,
    cpob_closest_if.source                      result
);
    import cpob_pkg::*;

    localparam int HALF_BITS = COORD_BITS - 1;
    localparam int PROD_BITS = COORD_BITS + ENTRY_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int DIST_BITS = SUM_BITS - AXIS_FRAC_BITS;

    localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
        {{(SUM_BITS-1){1'b0}}, 1'b1} << (AXIS_FRAC_BITS - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_MAX =
        {{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic [HALF_BITS-1:0]       HALF_ONE = HALF_BITS'(HALF_RESET);

    // Configuration registers
    logic [AXIS_BITS-1:0] axis_reg [NUM_AXES];
    logic [HALF_BITS-1:0] half_reg [NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg[0] <= AXIS_X_RESET;
            axis_reg[1] <= AXIS_Y_RESET;
            axis_reg[2] <= AXIS_Z_RESET;
            half_reg[0] <= HALF_ONE;
            half_reg[1] <= HALF_ONE;
            half_reg[2] <= HALF_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AXIS_COLUMN_X: axis_reg[0] <= cfg_data[AXIS_BITS-1:0];
                REG_AXIS_COLUMN_Y: axis_reg[1] <= cfg_data[AXIS_BITS-1:0];
                REG_AXIS_COLUMN_Z: axis_reg[2] <= cfg_data[AXIS_BITS-1:0];
                REG_HALF_EXTENT_X: half_reg[0] <= cfg_data[HALF_BITS-1:0];
                REG_HALF_EXTENT_Y: half_reg[1] <= cfg_data[HALF_BITS-1:0];
                REG_HALF_EXTENT_Z: half_reg[2] <= cfg_data[HALF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Unpacked axis entries: entry[axis][component]
    logic signed [ENTRY_BITS-1:0] entry [NUM_AXES][NUM_AXES];
    logic signed [COORD_BITS-1:0] pt    [NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                entry[i][k] = axis_reg[i][k*ENTRY_BITS +: ENTRY_BITS];
            end
        end
    end

    assign pt[0] = query.point_x;
    assign pt[1] = query.point_y;
    assign pt[2] = query.point_z;

    // Stage handshake: a stage loads when empty or when its successor moves
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] adv;

    always_comb
    begin
        adv[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || result.ready;
        for (int s = PIPE_STAGES - 2; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
        valid_next[0] = adv[0] ? query.valid : valid_reg[0];
        for (int s = 1; s < PIPE_STAGES; s++)
        begin
            valid_next[s] = adv[s] ? valid_reg[s-1] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign query.ready = adv[0];

    // Stage 1: projection products point[k] * axis[i][k]
    logic signed [PROD_BITS-1:0] proj_prod_reg  [NUM_AXES][NUM_AXES];
    logic signed [PROD_BITS-1:0] proj_prod_next [NUM_AXES][NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                proj_prod_next[i][k] = PROD_BITS'(pt[k]) * PROD_BITS'(entry[i][k]);
            end
        end
    end

    // Stage 2: dot product, rounded half up to coordinate precision
    logic signed [DIST_BITS-1:0] dist_reg  [NUM_AXES];
    logic signed [DIST_BITS-1:0] dist_next [NUM_AXES];
    logic signed [SUM_BITS-1:0]  dot_sum   [NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            dot_sum[i]   = SUM_BITS'(proj_prod_reg[i][0]) + SUM_BITS'(proj_prod_reg[i][1])
                         + SUM_BITS'(proj_prod_reg[i][2]) + ROUND_HALF;
            dist_next[i] = DIST_BITS'(dot_sum[i] >>> AXIS_FRAC_BITS);
        end
    end

    // Stage 3: clamp distance to +/- half-extent
    logic signed [COORD_BITS-1:0] clamp_reg  [NUM_AXES];
    logic signed [COORD_BITS-1:0] clamp_next [NUM_AXES];
    logic signed [SUM_BITS-1:0]   dist_ext   [NUM_AXES];
    logic signed [SUM_BITS-1:0]   half_pos   [NUM_AXES];
    logic signed [SUM_BITS-1:0]   half_neg   [NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            dist_ext[i] = SUM_BITS'(dist_reg[i]);
            half_pos[i] = $signed(SUM_BITS'(half_reg[i]));
            half_neg[i] = -half_pos[i];
            if (dist_ext[i] > half_pos[i])
            begin
                clamp_next[i] = COORD_BITS'(half_pos[i]);
            end
            else if (dist_ext[i] < half_neg[i])
            begin
                clamp_next[i] = COORD_BITS'(half_neg[i]);
            end
            else
            begin
                clamp_next[i] = COORD_BITS'(dist_ext[i]);
            end
        end
    end

    // Stage 4: back-projection products clamp[i] * axis[i][k], indexed [k][i]
    logic signed [PROD_BITS-1:0] back_prod_reg  [NUM_AXES][NUM_AXES];
    logic signed [PROD_BITS-1:0] back_prod_next [NUM_AXES][NUM_AXES];

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                back_prod_next[k][i] = PROD_BITS'(clamp_reg[i]) * PROD_BITS'(entry[i][k]);
            end
        end
    end

    // Stage 5: sum, round half up, saturate into the output register
    logic signed [COORD_BITS-1:0] out_reg  [NUM_AXES];
    logic signed [COORD_BITS-1:0] out_next [NUM_AXES];
    logic signed [SUM_BITS-1:0]   res_sum  [NUM_AXES];
    logic signed [SUM_BITS-1:0]   res_rnd  [NUM_AXES];

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            res_sum[k] = SUM_BITS'(back_prod_reg[k][0]) + SUM_BITS'(back_prod_reg[k][1])
                       + SUM_BITS'(back_prod_reg[k][2]) + ROUND_HALF;
            res_rnd[k] = res_sum[k] >>> AXIS_FRAC_BITS;
            if (res_rnd[k] > SAT_MAX)
            begin
                out_next[k] = COORD_BITS'(SAT_MAX);
            end
            else if (res_rnd[k] < SAT_MIN)
            begin
                out_next[k] = COORD_BITS'(SAT_MIN);
            end
            else
            begin
                out_next[k] = COORD_BITS'(res_rnd[k]);
            end
        end
    end

    // Payload registers, loaded as their stage advances
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            proj_prod_reg <= proj_prod_next;
        end
        if (adv[1])
        begin
            dist_reg <= dist_next;
        end
        if (adv[2])
        begin
            clamp_reg <= clamp_next;
        end
        if (adv[3])
        begin
            back_prod_reg <= back_prod_next;
        end
        if (adv[4])
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid     = valid_reg[PIPE_STAGES-1];
    assign result.closest_x = out_reg[0];
    assign result.closest_y = out_reg[1];
    assign result.closest_z = out_reg[2];

endmodule

### sv/cpob_checker.sv
// Port-level checks for the closest-point block, bound to the top level.
`timescale 1ns / 1ps

module cpob_checker #(
    parameter int COORD_BITS = cpob_pkg::COORD_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         q_valid,
    input logic                         q_ready,
    input logic                         r_valid,
    input logic                         r_ready,
    input logic signed [COORD_BITS-1:0] r_x,
    input logic signed [COORD_BITS-1:0] r_y,
    input logic signed [COORD_BITS-1:0] r_z
);
    import cpob_pkg::*;

    localparam int CNT_BITS = $clog2(PIPE_STAGES + 1) + 1;
    localparam logic [CNT_BITS-1:0] MAX_IN_FLIGHT = CNT_BITS'(PIPE_STAGES);

    // Transactions taken in but not yet delivered
    logic [CNT_BITS-1:0] in_flight_reg;
    logic [CNT_BITS-1:0] in_flight_next;
    logic                q_fire;
    logic                r_fire;

    assign q_fire = q_valid && q_ready;
    assign r_fire = r_valid && r_ready;

    always_comb
    begin
        in_flight_next = in_flight_reg + CNT_BITS'(q_fire) - CNT_BITS'(r_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= '0;
        end
        else
        begin
            in_flight_reg <= in_flight_next;
        end
    end

    // Never more in flight than there are stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= MAX_IN_FLIGHT)
        else $error("more transactions in flight than pipeline stages");

    // No result without an outstanding query
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> in_flight_reg != '0)
        else $error("result shown with no query outstanding");

    // With the sink ready while it passes through the stages, a query comes out as a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        q_fire ##1 r_ready ##1 r_ready ##1 r_ready ##1 r_ready |=> r_valid)
        else $error("result missing after pipeline latency");

    // Stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_x) && $stable(r_y) && $stable(r_z))
        else $error("stalled result changed or dropped");

endmodule

bind closest_point_on_oriented_box cpob_checker #(
    .COORD_BITS (COORD_BITS)
) u_cpob_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (query.valid),
    .q_ready (query.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_x     (result.closest_x),
    .r_y     (result.closest_y),
    .r_z     (result.closest_z)
);
